// File: rtl/lcdws_pkg.sv
// Shared types, constants and the control store (step program) for the
// character LCD write sequencer. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lcdws_pkg;

    // Request codes on the func input
    typedef enum logic [2:0] {
        FN_INIT   = 3'd0,
        FN_CMD    = 3'd1,
        FN_CHAR   = 3'd2,
        FN_CURSOR = 3'd3,
        FN_NUMBER = 3'd4,
        FN_GLYPH  = 3'd5
    } t_func;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_BUS_MODE = 2'd0,
        REG_FSET     = 2'd1,
        REG_DCTL     = 2'd2,
        REG_EMODE    = 2'd3
    } t_reg;

    typedef enum logic [1:0] {
        OP_EMIT  = 2'd0,   // send one byte (one or two transfers)
        OP_CONV  = 2'd1,   // one binary-to-BCD shift step
        OP_SKIPZ = 2'd2,   // drop one leading zero digit
        OP_HALT  = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        SRC_CONST  = 4'd0,
        SRC_FSET   = 4'd1,
        SRC_DCTL   = 4'd2,
        SRC_EMODE  = 4'd3,
        SRC_BYTE   = 4'd4,
        SRC_CURSOR = 4'd5,
        SRC_SLOT   = 4'd6,
        SRC_ROW    = 4'd7,
        SRC_DIGIT  = 4'd8
    } t_src;

    typedef enum logic [1:0] {
        COND_NONE   = 2'd0,
        COND_ROWS   = 2'd1,   // repeat step until all eight rows are out
        COND_DIGITS = 2'd2    // repeat step until the last digit is out
    } t_cond;

    typedef struct packed {
        t_op         op;
        t_src        src;
        logic [7:0]  k;
        logic        rs;
        logic [5:0]  wait_ms;
        logic        last;
        logic        only_neg;
        t_cond       cond;
    } t_cw;

    localparam int PC_W = 5;

    // Program entry points
    localparam logic [PC_W-1:0] PC_INIT8  = 5'd0;
    localparam logic [PC_W-1:0] PC_INIT4  = 5'd4;
    localparam logic [PC_W-1:0] PC_CMD    = 5'd10;
    localparam logic [PC_W-1:0] PC_CHAR   = 5'd11;
    localparam logic [PC_W-1:0] PC_CURSOR = 5'd12;
    localparam logic [PC_W-1:0] PC_GLYPH  = 5'd13;
    localparam logic [PC_W-1:0] PC_NUMBER = 5'd16;

    localparam logic [7:0] CMD_CLEAR   = 8'h01;
    localparam logic [7:0] CMD_CGRAM   = 8'h40;
    localparam logic [7:0] CMD_DDRAM   = 8'h80;
    localparam logic [7:0] INIT4_WAKE  = 8'h33;
    localparam logic [7:0] INIT4_NIB   = 8'h32;
    localparam logic [7:0] INIT4_FSET  = 8'h28;
    localparam logic [7:0] INIT4_DCTL  = 8'h0C;
    localparam logic [7:0] INIT4_EMODE = 8'h06;
    localparam logic [7:0] CHR_MINUS   = 8'h2D;
    localparam logic [7:0] CHR_ZERO    = 8'h30;
    localparam logic [7:0] LINE1_OFS   = 8'd64;

    localparam logic [5:0] WAIT_NONE  = 6'd0;
    localparam logic [5:0] WAIT_SHORT = 6'd1;
    localparam logic [5:0] WAIT_CLEAR = 6'd2;
    localparam logic [5:0] WAIT_POWER = 6'd50;

    localparam int         NUM_DIGITS = 10;
    localparam logic [3:0] NDIG_INIT  = 4'd10;

    localparam logic [7:0] RST_FSET  = 8'h38;
    localparam logic [7:0] RST_DCTL  = 8'h0C;
    localparam logic [7:0] RST_EMODE = 8'h06;

    function automatic t_cw mk_cw(input t_op op, input t_src src, input logic [7:0] k,
                                  input logic rs, input logic [5:0] w, input logic last,
                                  input logic only_neg, input t_cond cond);
        t_cw cw;
        cw.op       = op;
        cw.src      = src;
        cw.k        = k;
        cw.rs       = rs;
        cw.wait_ms  = w;
        cw.last     = last;
        cw.only_neg = only_neg;
        cw.cond     = cond;
        return cw;
    endfunction

    // Control store
    function automatic t_cw cw_at(input logic [PC_W-1:0] pc);
        t_cw cw;
        unique case (pc)
            // eight-bit init
            5'd0:  cw = mk_cw(OP_EMIT, SRC_FSET,  8'h00,       1'b0, WAIT_POWER, 1'b0, 1'b0,
                              COND_NONE);
            5'd1:  cw = mk_cw(OP_EMIT, SRC_DCTL,  8'h00,       1'b0, WAIT_SHORT, 1'b0, 1'b0,
                              COND_NONE);
            5'd2:  cw = mk_cw(OP_EMIT, SRC_CONST, CMD_CLEAR,   1'b0, WAIT_SHORT, 1'b0, 1'b0,
                              COND_NONE);
            5'd3:  cw = mk_cw(OP_EMIT, SRC_EMODE, 8'h00,       1'b0, WAIT_CLEAR, 1'b1, 1'b0,
                              COND_NONE);
            // four-bit init
            5'd4:  cw = mk_cw(OP_EMIT, SRC_CONST, INIT4_WAKE,  1'b0, WAIT_POWER, 1'b0, 1'b0,
                              COND_NONE);
            5'd5:  cw = mk_cw(OP_EMIT, SRC_CONST, INIT4_NIB,   1'b0, WAIT_SHORT, 1'b0, 1'b0,
                              COND_NONE);
            5'd6:  cw = mk_cw(OP_EMIT, SRC_CONST, INIT4_FSET,  1'b0, WAIT_SHORT, 1'b0, 1'b0,
                              COND_NONE);
            5'd7:  cw = mk_cw(OP_EMIT, SRC_CONST, INIT4_DCTL,  1'b0, WAIT_SHORT, 1'b0, 1'b0,
                              COND_NONE);
            5'd8:  cw = mk_cw(OP_EMIT, SRC_CONST, INIT4_EMODE, 1'b0, WAIT_SHORT, 1'b0, 1'b0,
                              COND_NONE);
            5'd9:  cw = mk_cw(OP_EMIT, SRC_CONST, CMD_CLEAR,   1'b0, WAIT_CLEAR, 1'b1, 1'b0,
                              COND_NONE);
            // single bytes
            5'd10: cw = mk_cw(OP_EMIT, SRC_BYTE,   8'h00, 1'b0, WAIT_NONE, 1'b1, 1'b0,
                              COND_NONE);
            5'd11: cw = mk_cw(OP_EMIT, SRC_BYTE,   8'h00, 1'b1, WAIT_NONE, 1'b1, 1'b0,
                              COND_NONE);
            5'd12: cw = mk_cw(OP_EMIT, SRC_CURSOR, 8'h00, 1'b0, WAIT_NONE, 1'b1, 1'b0,
                              COND_NONE);
            // custom glyph
            5'd13: cw = mk_cw(OP_EMIT, SRC_SLOT,  8'h00,     1'b0, WAIT_NONE, 1'b0, 1'b0,
                              COND_NONE);
            5'd14: cw = mk_cw(OP_EMIT, SRC_ROW,   8'h00,     1'b1, WAIT_NONE, 1'b0, 1'b0,
                              COND_ROWS);
            5'd15: cw = mk_cw(OP_EMIT, SRC_CONST, CMD_DDRAM, 1'b0, WAIT_NONE, 1'b1, 1'b0,
                              COND_NONE);
            // decimal number
            5'd16: cw = mk_cw(OP_CONV,  SRC_CONST, 8'h00,     1'b0, WAIT_NONE, 1'b0, 1'b0,
                              COND_NONE);
            5'd17: cw = mk_cw(OP_SKIPZ, SRC_CONST, 8'h00,     1'b0, WAIT_NONE, 1'b0, 1'b0,
                              COND_NONE);
            5'd18: cw = mk_cw(OP_EMIT,  SRC_CONST, CHR_MINUS, 1'b1, WAIT_NONE, 1'b0, 1'b1,
                              COND_NONE);
            5'd19: cw = mk_cw(OP_EMIT,  SRC_DIGIT, 8'h00,     1'b1, WAIT_NONE, 1'b0, 1'b0,
                              COND_DIGITS);
            default: cw = mk_cw(OP_HALT, SRC_CONST, 8'h00,    1'b0, WAIT_NONE, 1'b0, 1'b0,
                                COND_NONE);
        endcase
        return cw;
    endfunction

endpackage

`default_nettype wire

// File: rtl/char_lcd_write_sequencer_unit.sv
// Character LCD write sequencer: top level with step counter, control store
// lookup and datapath. Depends on lcdws_pkg.
`timescale 1ns / 1ps
`default_nettype none
// Each transfer is registered and shows in the cycle after its step; the first step runs in the cycle
// after start is taken, then one transfer per cycle from the byte/nibble emit step.
// A decimal number first runs the binary-to-BCD shift steps, then drops leading zero
// digits (up to 9), leaves the zero-drop step and, if positive, passes over the sign step.
// busy drops with the final transfer; the next item may start on the cycle it is shown.
// Results cannot be stalled. Reset (synchronous, active low) idles and loads defaults.

module char_lcd_write_sequencer_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  i_func,
    input  wire logic [7:0]  i_byte_value,
    input  wire logic        i_line,
    input  wire logic [5:0]  i_column,
    input  wire logic signed [31:0] i_number,
    input  wire logic [2:0]  i_glyph_slot,
    input  wire logic [63:0] i_glyph_rows,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [7:0]  i_cfg_wdata,
    output logic             o_valid,
    output logic             o_reg_select,
    output logic [7:0]       o_bus_data,
    output logic [5:0]       o_wait_before_ms,
    output logic             o_last
);
    import lcdws_pkg::*;

    // configuration
    logic       r_mode;
    logic [7:0] r_fset, r_dctl, r_emode;

    // sequencer control
    logic            r_run, n_run;
    logic [PC_W-1:0] r_pc, n_pc;
    logic            r_nib, n_nib;
    logic [2:0]      r_idx, n_idx;
    logic [4:0]      r_cnt, n_cnt;
    logic [3:0]      r_ndig, n_ndig;

    // request payload and working registers
    logic [7:0]  r_byte;
    logic        r_line;
    logic [5:0]  r_col;
    logic [2:0]  r_slot;
    logic [63:0] r_rows, n_rows;
    logic [31:0] r_bin, n_bin;
    logic        r_neg;
    logic [39:0] r_bcd, n_bcd;

    // result register
    logic       r_valid, n_valid;
    logic       r_rs, n_rs;
    logic [7:0] r_data, n_data;
    logic [5:0] r_wait, n_wait;
    logic       r_last, n_last;

    logic            accept;
    logic [PC_W-1:0] entry_pc;
    logic            entry_ok;
    logic [31:0]     mag;
    t_cw             cw;
    logic [7:0]      src_byte;
    logic [39:0]     bcd_adj;
    logic            hi_phase;
    logic            byte_last;

    assign accept = start && !busy;
    assign busy   = r_run;
    assign cw     = cw_at(r_pc);
    assign mag    = i_number[31] ? (32'd0 - i_number) : i_number;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= 1'b0;
            r_fset  <= RST_FSET;
            r_dctl  <= RST_DCTL;
            r_emode <= RST_EMODE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_BUS_MODE: r_mode  <= i_cfg_wdata[0];
                REG_FSET:     r_fset  <= i_cfg_wdata;
                REG_DCTL:     r_dctl  <= i_cfg_wdata;
                REG_EMODE:    r_emode <= i_cfg_wdata;
                default:      r_mode  <= r_mode;
            endcase
        end
    end

    // Dispatch: pick the program entry for the request code
    always_comb begin
        entry_ok = 1'b1;
        unique case (i_func)
            FN_INIT:   entry_pc = r_mode ? PC_INIT4 : PC_INIT8;
            FN_CMD:    entry_pc = PC_CMD;
            FN_CHAR:   entry_pc = PC_CHAR;
            FN_CURSOR: entry_pc = PC_CURSOR;
            FN_NUMBER: entry_pc = PC_NUMBER;
            FN_GLYPH:  entry_pc = PC_GLYPH;
            default: begin
                entry_pc = PC_INIT8;
                entry_ok = 1'b0;   // unused codes: drop the item
            end
        endcase
    end

    // Byte source selection
    always_comb begin
        unique case (cw.src)
            SRC_CONST:  src_byte = cw.k;
            SRC_FSET:   src_byte = r_fset;
            SRC_DCTL:   src_byte = r_dctl;
            SRC_EMODE:  src_byte = r_emode;
            SRC_BYTE:   src_byte = r_byte;
            SRC_CURSOR: src_byte = CMD_DDRAM + {2'b00, r_col} + (r_line ? LINE1_OFS : 8'd0);
            SRC_SLOT:   src_byte = CMD_CGRAM | {2'b00, r_slot, 3'b000};
            SRC_ROW:    src_byte = r_rows[7:0];
            SRC_DIGIT:  src_byte = CHR_ZERO | {4'd0, r_bcd[39:36]};
            default:    src_byte = 8'h00;
        endcase
    end

    // Add-3 correction on every BCD digit ahead of the shift
    always_comb begin
        for (int d = 0; d < NUM_DIGITS; d++) begin
            bcd_adj[4*d +: 4] = (r_bcd[4*d +: 4] >= 4'd5) ? (r_bcd[4*d +: 4] + 4'd3)
                                                           : r_bcd[4*d +: 4];
        end
    end

    assign hi_phase  = r_mode && !r_nib;
    assign byte_last = cw.last || ((cw.cond == COND_DIGITS) && (r_ndig == 4'd1));

    // Step execution
    always_comb begin
        n_run   = r_run;
        n_pc    = r_pc;
        n_nib   = r_nib;
        n_idx   = r_idx;
        n_cnt   = r_cnt;
        n_ndig  = r_ndig;
        n_rows  = r_rows;
        n_bin   = r_bin;
        n_bcd   = r_bcd;
        n_valid = 1'b0;
        n_rs    = r_rs;
        n_data  = r_data;
        n_wait  = r_wait;
        n_last  = r_last;

        if (r_run) begin
            unique case (cw.op)
                OP_EMIT: begin
                    if (cw.only_neg && !r_neg) begin
                        n_pc = r_pc + 1'b1;   // positive: no sign character
                    end else begin
                        n_valid = 1'b1;
                        n_rs    = cw.rs;
                        n_nib   = hi_phase;
                        if (hi_phase) begin
                            n_data = {src_byte[7:4], 4'h0};
                            n_wait = cw.wait_ms;
                            n_last = 1'b0;
                        end else begin
                            n_data = r_mode ? {src_byte[3:0], 4'h0} : src_byte;
                            n_wait = r_mode ? WAIT_NONE : cw.wait_ms;
                            n_last = byte_last;
                            if (byte_last) begin
                                n_run = 1'b0;
                            end else if (cw.cond == COND_ROWS) begin
                                n_rows = {8'h00, r_rows[63:8]};
                                n_idx  = r_idx + 1'b1;
                                if (r_idx == 3'd7) begin
                                    n_pc = r_pc + 1'b1;
                                end
                            end else if (cw.cond == COND_DIGITS) begin
                                n_bcd  = {r_bcd[35:0], 4'h0};
                                n_ndig = r_ndig - 1'b1;
                            end else begin
                                n_pc = r_pc + 1'b1;
                            end
                        end
                    end
                end
                OP_CONV: begin
                    n_bcd = {bcd_adj[38:0], r_bin[31]};
                    n_bin = {r_bin[30:0], 1'b0};
                    n_cnt = r_cnt + 1'b1;
                    if (r_cnt == 5'd31) begin
                        n_pc = r_pc + 1'b1;
                    end
                end
                OP_SKIPZ: begin
                    if ((r_bcd[39:36] == 4'd0) && (r_ndig != 4'd1)) begin
                        n_bcd  = {r_bcd[35:0], 4'h0};
                        n_ndig = r_ndig - 1'b1;
                    end else begin
                        n_pc = r_pc + 1'b1;
                    end
                end
                OP_HALT: begin
                    n_run = 1'b0;
                end
                default: n_run = 1'b0;
            endcase
        end else if (accept) begin
            n_run  = entry_ok;
            n_pc   = entry_pc;
            n_nib  = 1'b0;
            n_idx  = 3'd0;
            n_cnt  = 5'd0;
            n_ndig = NDIG_INIT;
            n_rows = i_glyph_rows;
            n_bin  = mag;
            n_bcd  = 40'd0;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run   <= 1'b0;
            r_pc    <= PC_INIT8;
            r_nib   <= 1'b0;
            r_idx   <= 3'd0;
            r_cnt   <= 5'd0;
            r_ndig  <= NDIG_INIT;
            r_valid <= 1'b0;
        end else begin
            r_run   <= n_run;
            r_pc    <= n_pc;
            r_nib   <= n_nib;
            r_idx   <= n_idx;
            r_cnt   <= n_cnt;
            r_ndig  <= n_ndig;
            r_valid <= n_valid;
        end
    end

    // Payload and working registers: hold request fields from accept
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_byte <= i_byte_value;
            r_line <= i_line;
            r_col  <= i_column;
            r_slot <= i_glyph_slot;
            r_neg  <= i_number[31];
        end
        r_rows <= n_rows;
        r_bin  <= n_bin;
        r_bcd  <= n_bcd;
        r_rs   <= n_rs;
        r_data <= n_data;
        r_wait <= n_wait;
        r_last <= n_last;
    end

    assign o_valid          = r_valid;
    assign o_reg_select     = r_rs;
    assign o_bus_data       = r_data;
    assign o_wait_before_ms = r_wait;
    assign o_last           = r_last;

    // A result only follows a cycle in which the sequencer was running
    a_valid_from_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_run))
        else $error("result strobe without a running request");

    // The final transfer ends the request
    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |-> !busy)
        else $error("busy still high after the final transfer");

    // A half-sent byte never survives the end of a request
    a_nib_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nib |-> r_run)
        else $error("nibble phase pending while idle");

    // Digit count never runs out
    a_ndig_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run |-> (r_ndig != 4'd0))
        else $error("digit counter reached zero");

    // Waits only ever go with command transfers
    a_wait_on_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_wait_before_ms != 6'd0)) |-> !o_reg_select)
        else $error("wait attached to a data transfer");

endmodule

`default_nettype wire

// File: tb/tb_char_lcd_write_sequencer_unit.sv
`timescale 1ns / 1ps
// Self-checking bench for char_lcd_write_sequencer_unit: issues display requests
// and register writes, predicts every bus transfer and compares field by field.
// Depends on lcdws_pkg (request and register codes) and the sequencer RTL.

module tb_char_lcd_write_sequencer_unit;
    import lcdws_pkg::*;

    // Run shape
    localparam int WATCHDOG_LIMIT = 2000;  // cycles with no item and no transfer
    localparam int TAIL_CYCLES    = 64;    // longest number conversion plus margin
    localparam int SETTLE_CYCLES  = 8;     // idle margin before a register write
    localparam int RANDOM_ITEMS   = 176;
    localparam int PHASE_ITEMS    = 22;
    localparam int N_DIR          = 12;

    // Request codes the block must ignore
    localparam logic [2:0] FN_SPARE6 = 3'd6;
    localparam logic [2:0] FN_SPARE7 = 3'd7;

    // Bytes and waits of the bus protocol, kept apart from the RTL package
    localparam logic [7:0]  DISP_CLEAR    = 8'h01;
    localparam logic [7:0]  LCD_CGRAM     = 8'h40;
    localparam logic [7:0]  LCD_DDRAM     = 8'h80;
    localparam logic [7:0]  LCD_LINE1     = 8'd64;
    localparam logic [7:0]  ASCII_MINUS   = 8'h2D;
    localparam logic [7:0]  ASCII_ZERO    = 8'h30;
    localparam logic [47:0] NIB_INIT_SEQ  = 48'h33_32_28_0C_06_01;
    localparam logic [5:0]  MS_POWER_UP   = 6'd50;
    localparam logic [5:0]  MS_CMD        = 6'd1;
    localparam logic [5:0]  MS_CLEAR      = 6'd2;
    localparam logic [5:0]  MS_NONE       = 6'd0;
    localparam logic [7:0]  DEF_FSET      = 8'h38;
    localparam logic [7:0]  DEF_DCTL      = 8'h0C;
    localparam logic [7:0]  DEF_EMODE     = 8'h06;

    // How a directed row is checked
    localparam logic [1:0] CHK_PREDICT = 2'd0;  // from the predictor
    localparam logic [1:0] CHK_NONE    = 2'd1;  // typed: no transfer at all
    localparam logic [1:0] CHK_ONE     = 2'd2;  // typed: one transfer

    localparam string PASS_MSG = "char_lcd_write_sequencer_unit: match";
    localparam string FAIL_MSG = "char_lcd_write_sequencer_unit: mismatch";

    typedef struct packed {
        logic       rs;
        logic [7:0] data;
        logic [5:0] wait_ms;
        logic       last;
    } t_lcd_xfer;

    typedef struct packed {
        logic [2:0]  fn;
        logic [7:0]  bv;
        logic        ln;
        logic [5:0]  col;
        logic [31:0] num;
        logic [2:0]  slot;
        logic [63:0] rows;
    } t_lcd_req;

    typedef struct packed {
        t_lcd_req   req;
        logic [1:0] chk;
        t_lcd_xfer  typed;
    } t_dir_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  i_func;
    logic [7:0]  i_byte_value;
    logic        i_line;
    logic [5:0]  i_column;
    logic [31:0] i_number;
    logic [2:0]  i_glyph_slot;
    logic [63:0] i_glyph_rows;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [7:0]  i_cfg_wdata;
    logic        o_valid;
    logic        o_reg_select;
    logic [7:0]  o_bus_data;
    logic [5:0]  o_wait_before_ms;
    logic        o_last;

    char_lcd_write_sequencer_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_func           (i_func),
        .i_byte_value     (i_byte_value),
        .i_line           (i_line),
        .i_column         (i_column),
        .i_number         (i_number),
        .i_glyph_slot     (i_glyph_slot),
        .i_glyph_rows     (i_glyph_rows),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_wdata      (i_cfg_wdata),
        .o_valid          (o_valid),
        .o_reg_select     (o_reg_select),
        .o_bus_data       (o_bus_data),
        .o_wait_before_ms (o_wait_before_ms),
        .o_last           (o_last)
    );

    // Register mirror for the predictor
    logic       mode_4bit;
    logic [7:0] fset_cmd;
    logic [7:0] dctl_cmd;
    logic [7:0] emode_cmd;

    t_lcd_xfer  staged[$];      // transfers of the request being predicted
    t_lcd_xfer  pending_xfers[$];
    t_dir_row   dir_rows [0:N_DIR-1];
    int         mismatch_count = 0;
    int         stall_cycles   = 0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Stage one byte: whole in eight-bit mode, high nibble then low nibble in
    // four-bit mode, with the wait only on the first half.
    function automatic void stage_byte(input logic rs, input logic [7:0] b,
                                       input logic [5:0] w);
        if (mode_4bit) begin
            staged.push_back({rs, b[7:4], 4'h0, w, 1'b0});
            staged.push_back({rs, b[3:0], 4'h0, MS_NONE, 1'b0});
        end else begin
            staged.push_back({rs, b, w, 1'b0});
        end
    endfunction

    function automatic void predict_transfers(input t_lcd_req r);
        logic [31:0] mag;
        logic [3:0]  digits [0:9];
        int          cnt;
        t_lcd_xfer   x;
        staged.delete();
        case (r.fn)
            FN_INIT: begin
                if (mode_4bit) begin
                    for (int i = 0; i < 6; i++)
                        stage_byte(1'b0, NIB_INIT_SEQ[47 - 8*i -: 8],
                                   (i == 0) ? MS_POWER_UP : (i == 5) ? MS_CLEAR : MS_CMD);
                end else begin
                    stage_byte(1'b0, fset_cmd, MS_POWER_UP);
                    stage_byte(1'b0, dctl_cmd, MS_CMD);
                    stage_byte(1'b0, DISP_CLEAR, MS_CMD);
                    stage_byte(1'b0, emode_cmd, MS_CLEAR);
                end
            end
            FN_CMD:    stage_byte(1'b0, r.bv, MS_NONE);
            FN_CHAR:   stage_byte(1'b1, r.bv, MS_NONE);
            FN_CURSOR: stage_byte(1'b0, LCD_DDRAM + {2'b00, r.col} + (r.ln ? LCD_LINE1 : 8'd0),
                                  MS_NONE);
            FN_NUMBER: begin
                // Unsigned negation also covers the most negative value
                mag = r.num;
                if (r.num[31]) begin
                    stage_byte(1'b1, ASCII_MINUS, MS_NONE);
                    mag = -r.num;
                end
                cnt = 0;
                do begin
                    digits[cnt] = 4'(mag % 10);
                    mag = mag / 10;
                    cnt++;
                end while (mag != 0);
                for (int i = cnt - 1; i >= 0; i--)
                    stage_byte(1'b1, ASCII_ZERO + {4'h0, digits[i]}, MS_NONE);
            end
            FN_GLYPH: begin
                stage_byte(1'b0, LCD_CGRAM + {2'b00, r.slot, 3'b000}, MS_NONE);
                for (int i = 0; i < 8; i++)
                    stage_byte(1'b1, r.rows[8*i +: 8], MS_NONE);
                stage_byte(1'b0, LCD_DDRAM, MS_NONE);
            end
            default: ;  // spare codes produce nothing
        endcase
        if (staged.size() > 0) begin
            x = staged.pop_back();
            x.last = 1'b1;
            staged.push_back(x);
        end
        foreach (staged[i])
            pending_xfers.push_back(staged[i]);
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input t_lcd_xfer want,
                                   input t_lcd_xfer got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t %s: exp rs=%0d d=%02h w=%0d l=%0d, act rs=%0d d=%02h w=%0d l=%0d",
                     $time, what, want.rs, want.data, want.wait_ms, want.last,
                     got.rs, got.data, got.wait_ms, got.last);
    endtask

    // Results cannot be held off: take each strobed transfer at the edge that
    // ends its cycle and compare it with the oldest prediction.
    always @(posedge i_clk) begin
        t_lcd_xfer got;
        t_lcd_xfer want;
        if (i_rst_n && o_valid !== 1'b0) begin
            got = {o_reg_select, o_bus_data, o_wait_before_ms, o_last};
            if (pending_xfers.size() == 0) begin
                report_mismatch("transfer with nothing pending", '0, got);
            end else begin
                want = pending_xfers.pop_front();
                if (got.rs !== want.rs || got.data !== want.data ||
                    got.wait_ms !== want.wait_ms || got.last !== want.last)
                    report_mismatch("transfer differs", want, got);
            end
        end
    end

    // Count cycles in which neither an item nor a transfer moves
    always @(posedge i_clk) begin
        if (i_rst_n && ((start && busy === 1'b0) || o_valid === 1'b1))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
            $display(FAIL_MSG);
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    // Present a request and hold it until the block takes it; start stays high
    // afterwards so that a back-to-back item needs no extra edge.
    task automatic send_request(input t_lcd_req r, input logic [1:0] chk,
                                input t_lcd_xfer typed);
        @(negedge i_clk);
        i_func       = r.fn;
        i_byte_value = r.bv;
        i_line       = r.ln;
        i_column     = r.col;
        i_number     = r.num;
        i_glyph_slot = r.slot;
        i_glyph_rows = r.rows;
        start        = 1'b1;
        do @(posedge i_clk); while (busy !== 1'b0);
        case (chk)
            CHK_ONE:  pending_xfers.push_back(typed);
            CHK_NONE: ;
            default:  predict_transfers(r);
        endcase
    endtask

    task automatic idle_sender(input int cycles);
        @(negedge i_clk);
        start = 1'b0;
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    // Hold off until every predicted transfer is out and the block is idle,
    // then leave room for a request that produces nothing.
    task automatic drain_block;
        @(negedge i_clk);
        start = 1'b0;
        while (pending_xfers.size() != 0 || busy !== 1'b0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg idx, input logic [7:0] val);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_idx   = idx;
        i_cfg_wdata = val;
        @(posedge i_clk);
        case (idx)
            REG_BUS_MODE: mode_4bit = val[0];
            REG_FSET:     fset_cmd  = val;
            REG_DCTL:     dctl_cmd  = val;
            REG_EMODE:    emode_cmd = val;
            default: ;
        endcase
    endtask

    task automatic configure(input logic mode, input logic [7:0] fset,
                             input logic [7:0] dctl, input logic [7:0] emode);
        logic [7:0] w;
        w    = 8'($urandom);     // upper bits of the mode write are don't-care
        w[0] = mode;
        write_reg(REG_BUS_MODE, w);
        write_reg(REG_FSET, fset);
        write_reg(REG_DCTL, dctl);
        write_reg(REG_EMODE, emode);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    function automatic logic [7:0] pick_cmd_byte();
        case ($urandom_range(0, 3))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [31:0] pick_number();
        logic [31:0] p;
        case ($urandom_range(0, 5))
            0: p = $urandom_range(0, 99);
            1: begin
                // Powers of ten exercise trailing zeros
                p = 1;
                repeat ($urandom_range(0, 9)) p = p * 10;
                p = p * $urandom_range(1, 2);
            end
            2: begin
                case ($urandom_range(0, 3))
                    0:       p = 32'h8000_0000;
                    1:       p = 32'h7FFF_FFFF;
                    2:       p = 32'hFFFF_FFFF;
                    default: p = 32'h0000_0000;
                endcase
                return p;
            end
            default: return $urandom;
        endcase
        if ($urandom_range(0, 1))
            p = -p;
        return p;
    endfunction

    function automatic t_lcd_req rand_request();
        t_lcd_req r;
        r.bv   = 8'($urandom);
        r.ln   = 1'($urandom);
        r.col  = 6'($urandom);
        r.num  = pick_number();
        r.slot = 3'($urandom);
        r.rows = {$urandom, $urandom};
        if ($urandom_range(0, 99) < 6)
            r.fn = $urandom_range(0, 1) ? FN_SPARE6 : FN_SPARE7;
        else
            r.fn = 3'($urandom_range(FN_INIT, FN_GLYPH));
        return r;
    endfunction

    function automatic t_dir_row mk_row(input logic [2:0] fn, input logic [7:0] bv,
                                        input logic ln, input logic [5:0] col,
                                        input logic [31:0] num, input logic [2:0] slot,
                                        input logic [63:0] rows, input logic [1:0] chk,
                                        input t_lcd_xfer typed);
        t_dir_row d;
        d.req   = {fn, bv, ln, col, num, slot, rows};
        d.chk   = chk;
        d.typed = typed;
        return d;
    endfunction

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        t_lcd_req   r;
        int         accepted;
        int         g;
        int         phase;
        logic       burst;
        logic       mode;
        logic [7:0] fs;
        logic [7:0] dc;
        logic [7:0] em;

        start        = 1'b0;
        i_rst_n      = 1'b0;
        i_func       = '0;
        i_byte_value = '0;
        i_line       = 1'b0;
        i_column     = '0;
        i_number     = '0;
        i_glyph_slot = '0;
        i_glyph_rows = '0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = '0;
        i_cfg_wdata  = '0;
        mode_4bit    = 1'b0;
        fset_cmd     = DEF_FSET;
        dctl_cmd     = DEF_DCTL;
        emode_cmd    = DEF_EMODE;

        // Directed rows; typed transfers hold for the eight-bit reset setting
        dir_rows[0]  = mk_row(FN_INIT,   8'h00, 1'b0, 6'd0,  32'd0, 3'd0, 64'd0,
                              CHK_PREDICT, '0);
        dir_rows[1]  = mk_row(FN_CMD,    8'h00, 1'b0, 6'd0,  32'd0, 3'd0, 64'd0,
                              CHK_ONE, {1'b0, 8'h00, MS_NONE, 1'b1});
        dir_rows[2]  = mk_row(FN_CMD,    8'hFF, 1'b0, 6'd0,  32'd0, 3'd0, 64'd0,
                              CHK_ONE, {1'b0, 8'hFF, MS_NONE, 1'b1});
        dir_rows[3]  = mk_row(FN_CHAR,   8'h00, 1'b0, 6'd0,  32'd0, 3'd0, 64'd0,
                              CHK_ONE, {1'b1, 8'h00, MS_NONE, 1'b1});
        dir_rows[4]  = mk_row(FN_CHAR,   8'hFF, 1'b0, 6'd0,  32'd0, 3'd0, 64'd0,
                              CHK_ONE, {1'b1, 8'hFF, MS_NONE, 1'b1});
        // Cursor corners: first cell of line 0, top of the address range on line 1
        dir_rows[5]  = mk_row(FN_CURSOR, 8'h00, 1'b0, 6'd0,  32'd0, 3'd0, 64'd0,
                              CHK_ONE, {1'b0, 8'h80, MS_NONE, 1'b1});
        dir_rows[6]  = mk_row(FN_CURSOR, 8'h00, 1'b1, 6'd63, 32'd0, 3'd0, 64'd0,
                              CHK_ONE, {1'b0, 8'hFF, MS_NONE, 1'b1});
        // Zero prints one digit; then the two signed extremes
        dir_rows[7]  = mk_row(FN_NUMBER, 8'h00, 1'b0, 6'd0,  32'd0, 3'd0, 64'd0,
                              CHK_ONE, {1'b1, ASCII_ZERO, MS_NONE, 1'b1});
        dir_rows[8]  = mk_row(FN_NUMBER, 8'h00, 1'b0, 6'd0,  32'h8000_0000, 3'd0, 64'd0,
                              CHK_PREDICT, '0);
        dir_rows[9]  = mk_row(FN_NUMBER, 8'h00, 1'b0, 6'd0,  32'h7FFF_FFFF, 3'd0, 64'd0,
                              CHK_PREDICT, '0);
        dir_rows[10] = mk_row(FN_GLYPH,  8'h00, 1'b0, 6'd0,  32'd0, 3'd7, {64{1'b1}},
                              CHK_PREDICT, '0);
        dir_rows[11] = mk_row(FN_SPARE6, 8'h00, 1'b0, 6'd0,  32'd0, 3'd0, 64'd0,
                              CHK_NONE, '0);

        // Hold reset low, release on a falling edge
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Walk the table at the reset setting, typed rows as given
        for (int i = 0; i < N_DIR; i++) begin
            send_request(dir_rows[i].req, dir_rows[i].chk, dir_rows[i].typed);
            g = pick_gap();
            if (g > 0) idle_sender(g);
        end

        // Walk it again on the nibble bus; init must ignore the command registers
        drain_block();
        configure(1'b1, 8'h00, 8'h00, 8'h00);
        for (int i = 0; i < N_DIR; i++) begin
            send_request(dir_rows[i].req, CHK_PREDICT, '0);
            g = pick_gap();
            if (g > 0) idle_sender(g);
        end

        // Random phases, a fresh register setting at each boundary
        accepted = 0;
        phase    = 0;
        while (accepted < RANDOM_ITEMS) begin
            drain_block();
            case (phase)
                0: begin mode = 1'b0; fs = 8'hFF; dc = 8'hFF; em = 8'hFF; end
                1: begin mode = 1'b1; fs = 8'hFF; dc = 8'hFF; em = 8'hFF; end
                2: begin mode = 1'b0; fs = 8'h00; dc = 8'h00; em = 8'h00; end
                default: begin
                    mode = 1'($urandom);
                    fs   = pick_cmd_byte();
                    dc   = pick_cmd_byte();
                    em   = pick_cmd_byte();
                end
            endcase
            configure(mode, fs, dc, em);
            // Some phases run back to back with no random idle gaps between items
            burst = ($urandom_range(0, 2) == 0);
            for (int j = 0; j < PHASE_ITEMS && accepted < RANDOM_ITEMS; ) begin
                r = rand_request();
                send_request(r, CHK_PREDICT, '0);
                if (r.fn <= FN_GLYPH) begin
                    accepted++;
                    j++;
                end
                if ($urandom_range(0, 99) < 4) begin
                    drain_block();
                end else if (!burst) begin
                    g = pick_gap();
                    if (g > 0) idle_sender(g);
                end
            end
            phase++;
        end

        // Let the last transfers come out, then watch for strays
        @(negedge i_clk);
        start = 1'b0;
        while (pending_xfers.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && pending_xfers.size() == 0)
            $display(PASS_MSG);
        else
            $display(FAIL_MSG);
        $finish;
    end

endmodule

// File: filelist.f
rtl/lcdws_pkg.sv
rtl/char_lcd_write_sequencer_unit.sv
tb/tb_char_lcd_write_sequencer_unit.sv
